// ===== rtl/core/triangle_normal_and_area_unit_assert.svh =====
// Assertion helpers for the unit's RTL
`ifndef TRIANGLE_NORMAL_AND_AREA_UNIT_ASSERT_SVH
`define TRIANGLE_NORMAL_AND_AREA_UNIT_ASSERT_SVH

// check prop at every rising edge of clk outside reset
`define TNAU_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tnau assertion failed");

// same, on the unit's clock and reset
`define TNAU_ASSERT(label, prop) \
   `TNAU_ASSERT_CLK(label, clock, reset, prop)

`endif

// ===== rtl/core/tna_pkg.sv =====
`timescale 1ns / 1ps
package tna_pkg;

   localparam int CW  = 16;            // coordinate width
   localparam int EW  = CW + 1;        // edge width
   localparam int PW  = 2 * EW;        // edge product width
   localparam int CRW = PW + 1;        // cross product component width
   localparam int AW  = PW;            // cross magnitude width
   localparam int HW  = (AW + 1) / 2;  // half of a magnitude, for squaring
   localparam int SW  = 2 * AW + 2;    // sum of squares width
   localparam int RW  = AW;            // root width
   localparam int NF  = 15;            // fraction bits of the normal
   localparam int DS  = NF + 1;        // divider stages
   localparam int QW  = NF + 2;        // quotient width with rounding headroom
   localparam int AREA_W = 35;
   localparam int NW  = 16;

   localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
   localparam logic [NW-1:0] NORMAL_POS_MAX = {1'b0, {(NW-1){1'b1}}};

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOT_TRI = 2'd1,
      ST_DEGEN   = 2'd2
   } status_type;

   typedef struct packed {
      logic is_triangle;
      logic signed [CW-1:0] p1_x;
      logic signed [CW-1:0] p1_y;
      logic signed [CW-1:0] p1_z;
      logic signed [CW-1:0] p2_x;
      logic signed [CW-1:0] p2_y;
      logic signed [CW-1:0] p2_z;
      logic signed [CW-1:0] p3_x;
      logic signed [CW-1:0] p3_y;
      logic signed [CW-1:0] p3_z;
   } req_type;

   typedef struct packed {
      logic [AREA_W-1:0] face_area;
      logic signed [NW-1:0] norm_x;
      logic signed [NW-1:0] normal_y;
      logic signed [NW-1:0] normal_z;
      logic [1:0] face_status;
   } rsp_type;

   // control and magnitudes that ride along the root and divide pipes
   typedef struct packed {
      logic valid;
      status_type status;
      logic [2:0] neg;
      logic [2:0][AW-1:0] mag;
   } side_type;

endpackage

// ===== rtl/core/triangle_normal_and_area_unit.sv =====
`timescale 1ns / 1ps
// Triangle normal and area unit. Takes one face word per cycle while req_stall
// is low and returns one result word per face, in order, after 7 stages of
// edge, cross product and sum-of-squares arithmetic, 34 stages of square root
// (one root bit per stage), 16 stages of normal division (one quotient bit
// per stage) and the output register. A stall on a valid result freezes the
// whole pipeline, and req_stall follows it in the same cycle.
`include "triangle_normal_and_area_unit_assert.svh"

module triangle_normal_and_area_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tna_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tna_pkg::rsp_type rsp_data
);

   logic rsp_valid_ff;
   tna_pkg::rsp_type rsp_ff;

   logic en;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign en        = ~req_stall;

   // stage 1: edges
   logic                       s1_valid_ff, s1_tri_ff;
   logic signed [tna_pkg::EW-1:0] e1_ff [3];
   logic signed [tna_pkg::EW-1:0] e2_ff [3];
   // stage 2: products
   logic                       s2_valid_ff, s2_tri_ff;
   logic signed [tna_pkg::PW-1:0] pa_ff [3];
   logic signed [tna_pkg::PW-1:0] pb_ff [3];
   // stage 3: cross product
   logic                       s3_valid_ff, s3_tri_ff;
   logic signed [tna_pkg::CRW-1:0] c_ff [3];
   // stage 4: magnitudes
   tna_pkg::side_type          s4_ff;
   // stage 5: partial squares
   tna_pkg::side_type          s5_ff;
   logic [2*tna_pkg::HW-1:0]   hh_ff [3];
   logic [2*tna_pkg::HW-1:0]   hl_ff [3];
   logic [2*tna_pkg::HW-1:0]   ll_ff [3];
   // stage 6: squares
   tna_pkg::side_type          s6_ff;
   logic [2*tna_pkg::AW-1:0]   sq_ff [3];
   // stage 7: sum of squares
   tna_pkg::side_type          s7_ff;
   logic [tna_pkg::SW-1:0]     sum_ff;

   logic signed [tna_pkg::EW-1:0] e1_in [3];
   logic signed [tna_pkg::EW-1:0] e2_in [3];
   logic signed [tna_pkg::CW-1:0] pv [9];

   always_comb begin
      pv[0] = req_data.p1_x; pv[1] = req_data.p1_y; pv[2] = req_data.p1_z;
      pv[3] = req_data.p2_x; pv[4] = req_data.p2_y; pv[5] = req_data.p2_z;
      pv[6] = req_data.p3_x; pv[7] = req_data.p3_y; pv[8] = req_data.p3_z;
      for (int j = 0; j < 3; j++) begin
         e1_in[j] = tna_pkg::EW'(pv[3+j]) - tna_pkg::EW'(pv[j]);
         e2_in[j] = tna_pkg::EW'(pv[6+j]) - tna_pkg::EW'(pv[3+j]);
      end
   end

   tna_pkg::side_type s4_in;
   always_comb begin
      s4_in.valid = s3_valid_ff;
      for (int j = 0; j < 3; j++) begin
         s4_in.neg[j] = c_ff[j][tna_pkg::CRW-1];
         s4_in.mag[j] = c_ff[j][tna_pkg::CRW-1] ? tna_pkg::AW'(-c_ff[j])
                                                 : tna_pkg::AW'(c_ff[j]);
      end
      if (!s3_tri_ff) begin
         s4_in.status = tna_pkg::ST_NOT_TRI;
      end else if (c_ff[0] == '0 && c_ff[1] == '0 && c_ff[2] == '0) begin
         s4_in.status = tna_pkg::ST_DEGEN;
      end else begin
         s4_in.status = tna_pkg::ST_OK;
      end
   end

   logic [2*tna_pkg::HW-1:0] mag_x [3];
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         mag_x[j] = (2*tna_pkg::HW)'(s4_ff.mag[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
         s7_ff.valid <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_ff       <= s4_in;
         s5_ff       <= s4_ff;
         s6_ff       <= s5_ff;
         s7_ff       <= s6_ff;
      end
      if (en) begin
         s1_tri_ff <= req_data.is_triangle;
         s2_tri_ff <= s1_tri_ff;
         s3_tri_ff <= s2_tri_ff;
         for (int j = 0; j < 3; j++) begin
            e1_ff[j] <= e1_in[j];
            e2_ff[j] <= e2_in[j];
            hh_ff[j] <= mag_x[j][2*tna_pkg::HW-1:tna_pkg::HW]
                        * mag_x[j][2*tna_pkg::HW-1:tna_pkg::HW];
            hl_ff[j] <= mag_x[j][2*tna_pkg::HW-1:tna_pkg::HW]
                        * mag_x[j][tna_pkg::HW-1:0];
            ll_ff[j] <= mag_x[j][tna_pkg::HW-1:0] * mag_x[j][tna_pkg::HW-1:0];
            sq_ff[j] <= (2*tna_pkg::AW)'(
                           ((2*tna_pkg::AW+2)'(hh_ff[j]) << (2*tna_pkg::HW))
                         + ((2*tna_pkg::AW+2)'(hl_ff[j]) << (tna_pkg::HW + 1))
                         + (2*tna_pkg::AW+2)'(ll_ff[j]));
         end
         pa_ff[0] <= e1_ff[1] * e2_ff[2];  pb_ff[0] <= e1_ff[2] * e2_ff[1];
         pa_ff[1] <= e1_ff[2] * e2_ff[0];  pb_ff[1] <= e1_ff[0] * e2_ff[2];
         pa_ff[2] <= e1_ff[0] * e2_ff[1];  pb_ff[2] <= e1_ff[1] * e2_ff[0];
         for (int j = 0; j < 3; j++) begin
            c_ff[j] <= tna_pkg::CRW'(pa_ff[j]) - tna_pkg::CRW'(pb_ff[j]);
         end
         sum_ff <= tna_pkg::SW'(sq_ff[0]) + tna_pkg::SW'(sq_ff[1]) + tna_pkg::SW'(sq_ff[2]);
      end
   end

   logic [tna_pkg::RW-1:0] root;
   tna_pkg::side_type      sq_side;

   tna_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .s_in     (sum_ff),
      .side_in  (s7_ff),
      .root_out (root),
      .side_out (sq_side)
   );

   logic [2:0][tna_pkg::QW-1:0] dq;
   logic [2:0][tna_pkg::RW:0]   dr;
   logic [tna_pkg::RW-1:0]      dm;
   tna_pkg::side_type           dside;

   tna_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .m_in     (root),
      .side_in  (sq_side),
      .q_out    (dq),
      .r_out    (dr),
      .m_out    (dm),
      .side_out (dside)
   );

   // output stage: round, saturate, area
   localparam int LW = (tna_pkg::RW > tna_pkg::AREA_W) ? tna_pkg::RW : tna_pkg::AREA_W;
   logic [LW-1:0]              half;
   logic [tna_pkg::AREA_W-1:0] area;
   logic [tna_pkg::QW-1:0]     qr [3];
   logic [tna_pkg::NW-1:0]     nv [3];
   tna_pkg::rsp_type           rsp_in;

   always_comb begin
      half = LW'(dm >> 1);
      area = (half > LW'(tna_pkg::AREA_MAX)) ? tna_pkg::AREA_MAX : tna_pkg::AREA_W'(half);
      for (int j = 0; j < 3; j++) begin
         qr[j] = dq[j] + tna_pkg::QW'({dr[j], 1'b0} >= (tna_pkg::RW + 2)'(dm));
         if (qr[j] > (tna_pkg::QW'(1) << tna_pkg::NF)) begin
            qr[j] = tna_pkg::QW'(1) << tna_pkg::NF;
         end
         if (dside.neg[j]) begin
            nv[j] = tna_pkg::NW'(-qr[j]);
         end else if (qr[j] > tna_pkg::QW'(tna_pkg::NORMAL_POS_MAX)) begin
            nv[j] = tna_pkg::NORMAL_POS_MAX;
         end else begin
            nv[j] = tna_pkg::NW'(qr[j]);
         end
      end
      rsp_in.face_status = dside.status;
      case (dside.status)
         tna_pkg::ST_NOT_TRI: begin
            rsp_in.face_area = '0;
            rsp_in.norm_x    = tna_pkg::NORMAL_POS_MAX;
            rsp_in.normal_y  = tna_pkg::NORMAL_POS_MAX;
            rsp_in.normal_z  = tna_pkg::NORMAL_POS_MAX;
         end
         tna_pkg::ST_DEGEN: begin
            rsp_in.face_area = '0;
            rsp_in.norm_x    = '0;
            rsp_in.normal_y  = '0;
            rsp_in.normal_z  = '0;
         end
         default: begin
            rsp_in.face_area = area;
            rsp_in.norm_x    = nv[0];
            rsp_in.normal_y  = nv[1];
            rsp_in.normal_z  = nv[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dside.valid;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TNAU_ASSERT(a_status_code, !rsp_valid_ff || rsp_ff.face_status != 2'd3)
   `TNAU_ASSERT(a_ok_normal_nonzero,
      !(rsp_valid_ff && rsp_ff.face_status == tna_pkg::ST_OK)
      || rsp_ff.norm_x != '0 || rsp_ff.normal_y != '0 || rsp_ff.normal_z != '0)
   `TNAU_ASSERT(a_special_area_zero,
      !(rsp_valid_ff && rsp_ff.face_status != tna_pkg::ST_OK) || rsp_ff.face_area == '0)

endmodule

// ===== rtl/core/tna_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// Integer square root, one root bit per stage.
module tna_sqrt_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [tna_pkg::SW-1:0]        s_in,
   input  tna_pkg::side_type             side_in,
   output logic [tna_pkg::RW-1:0]        root_out,
   output tna_pkg::side_type             side_out
);

   logic [tna_pkg::SW-1:0] rem_ff  [tna_pkg::RW];
   logic [tna_pkg::RW-1:0] root_ff [tna_pkg::RW];
   tna_pkg::side_type      side_ff [tna_pkg::RW];

   genvar i;
   generate
      for (i = 0; i < tna_pkg::RW; i++) begin : g_stage
         localparam int B = tna_pkg::RW - 1 - i;
         logic [tna_pkg::SW-1:0] rem_src;
         logic [tna_pkg::RW-1:0] root_src;
         tna_pkg::side_type      side_src;
         logic [tna_pkg::SW-1:0] trial;
         logic [tna_pkg::SW-1:0] rem_in;
         logic [tna_pkg::RW-1:0] root_in;
         logic                   take;

         if (i == 0) begin : g_first
            assign rem_src  = s_in;
            assign root_src = '0;
            assign side_src = side_in;
         end else begin : g_next
            assign rem_src  = rem_ff[i-1];
            assign root_src = root_ff[i-1];
            assign side_src = side_ff[i-1];
         end

         // trial = 2*r*2^B + 2^(2B)
         always_comb begin
            trial   = (tna_pkg::SW'(root_src) << (B + 1)) + (tna_pkg::SW'(1) << (2 * B));
            take    = (rem_src >= trial);
            rem_in  = take ? (rem_src - trial) : rem_src;
            root_in = take ? (root_src | (tna_pkg::RW'(1) << B)) : root_src;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               side_ff[i].valid <= 1'b0;
            end else if (en) begin
               side_ff[i] <= side_src;
            end
            if (en) begin
               rem_ff[i]  <= rem_in;
               root_ff[i] <= root_in;
            end
         end
      end
   endgenerate

   assign root_out = root_ff[tna_pkg::RW-1];
   assign side_out = side_ff[tna_pkg::RW-1];

endmodule

// ===== rtl/core/tna_div_pipe.sv =====
`timescale 1ns / 1ps
// Three restoring fraction dividers mag/m in lockstep, one quotient bit per stage.
module tna_div_pipe (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic [tna_pkg::RW-1:0]             m_in,
   input  tna_pkg::side_type                  side_in,
   output logic [2:0][tna_pkg::QW-1:0]        q_out,
   output logic [2:0][tna_pkg::RW:0]          r_out,
   output logic [tna_pkg::RW-1:0]             m_out,
   output tna_pkg::side_type                  side_out
);

   logic [2:0][tna_pkg::QW-1:0] q_ff    [tna_pkg::DS];
   logic [2:0][tna_pkg::RW:0]   r_ff    [tna_pkg::DS];
   logic [tna_pkg::RW-1:0]      m_ff    [tna_pkg::DS];
   tna_pkg::side_type           side_ff [tna_pkg::DS];

   genvar i, k;
   generate
      for (i = 0; i < tna_pkg::DS; i++) begin : g_stage
         logic [2:0][tna_pkg::QW-1:0] q_in;
         logic [2:0][tna_pkg::RW:0]   r_in;
         logic [tna_pkg::RW-1:0]      m_src;
         tna_pkg::side_type           side_src;

         if (i == 0) begin : g_first
            assign m_src    = m_in;
            assign side_src = side_in;
            for (k = 0; k < 3; k++) begin : g_comp
               logic ge;
               always_comb begin
                  ge      = (side_in.mag[k] >= m_in);
                  q_in[k] = tna_pkg::QW'(ge);
                  r_in[k] = ge ? tna_pkg::RW'(side_in.mag[k] - m_in) + (tna_pkg::RW + 1)'(0)
                               : (tna_pkg::RW + 1)'(side_in.mag[k]);
               end
            end
         end else begin : g_next
            assign m_src    = m_ff[i-1];
            assign side_src = side_ff[i-1];
            for (k = 0; k < 3; k++) begin : g_comp
               logic [tna_pkg::RW:0] r2;
               logic                 ge;
               always_comb begin
                  r2      = {r_ff[i-1][k][tna_pkg::RW-1:0], 1'b0};
                  ge      = (r2 >= (tna_pkg::RW + 1)'(m_ff[i-1]));
                  r_in[k] = ge ? (r2 - (tna_pkg::RW + 1)'(m_ff[i-1])) : r2;
                  q_in[k] = {q_ff[i-1][k][tna_pkg::QW-2:0], ge};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               side_ff[i].valid <= 1'b0;
            end else if (en) begin
               side_ff[i] <= side_src;
            end
            if (en) begin
               q_ff[i] <= q_in;
               r_ff[i] <= r_in;
               m_ff[i] <= m_src;
            end
         end
      end
   endgenerate

   assign q_out    = q_ff[tna_pkg::DS-1];
   assign r_out    = r_ff[tna_pkg::DS-1];
   assign m_out    = m_ff[tna_pkg::DS-1];
   assign side_out = side_ff[tna_pkg::DS-1];

endmodule
